// ===== rtl/core/rdsc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdsc_pkg
// Shared types, constants and digit helpers for the radix digit string
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rdsc_pkg;

    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd16;
    localparam logic [RADIX_W-1:0] DEC_BASE    = 6'd10;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'd65;
    localparam logic [CHAR_W-1:0] ASCII_Z    = 7'd90;

    typedef struct packed {
        logic clear;
        logic step;
        logic shift;
    } cell_ctl_t;

    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN)
        begin
            res = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        logic [CHAR_W-1:0] res;
        dx  = {1'b0, d};
        res = dx + ASCII_ZERO;
        if (d >= DEC_BASE)
        begin
            res = dx - {1'b0, DEC_BASE} + ASCII_A;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rdsc_cell.sv =====
// ----------------------------------------------------------------------------
// rdsc_cell
// One radix digit cell: doubles its digit and adds the incoming bit, folds
// back by the radix and passes the carry on; shifts digits during readout.
// ----------------------------------------------------------------------------
`default_nettype none

module rdsc_cell (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire rdsc_pkg::cell_ctl_t             ctl,
    input  wire logic [rdsc_pkg::RADIX_W-1:0]    radix,
    input  wire logic                            carry_in,
    input  wire logic                            en_in,
    input  wire logic [rdsc_pkg::RADIX_W-1:0]    digit_in,
    output logic [rdsc_pkg::RADIX_W-1:0]         digit,
    output logic                                 carry_out,
    output logic                                 en_out
);

    logic [rdsc_pkg::RADIX_W-1:0] digit_reg;
    logic [rdsc_pkg::RADIX_W-1:0] digit_next;
    logic                         carry_reg;
    logic                         carry_next;
    logic                         en_reg;
    logic                         en_next;
    logic [rdsc_pkg::RADIX_W:0]   dbl;
    logic                         ge;

    always_comb
    begin
        dbl        = {digit_reg, carry_in};
        ge         = (dbl >= {1'b0, radix});
        digit_next = digit_reg;
        carry_next = carry_reg;
        en_next    = en_reg;
        if (ctl.clear)
        begin
            digit_next = '0;
            carry_next = 1'b0;
            en_next    = 1'b0;
        end
        else if (ctl.step)
        begin
            en_next    = en_in;
            carry_next = en_in & ge;
            if (en_in)
            begin
                if (ge)
                begin
                    digit_next = rdsc_pkg::RADIX_W'(dbl - {1'b0, radix});
                end
                else
                begin
                    digit_next = dbl[rdsc_pkg::RADIX_W-1:0];
                end
            end
        end
        else if (ctl.shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= 1'b0;
            en_reg    <= 1'b0;
        end
        else
        begin
            carry_reg <= carry_next;
            en_reg    <= en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit     = digit_reg;
    assign carry_out = carry_reg;
    assign en_out    = en_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rdsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rdsc_ctrl
// Sequencer: radix register, input bit shifter, conversion and readout
// counters, leading zero suppression and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rdsc_ctrl #(
    parameter int VALUE_BITS = 31,
    parameter int MAX_DIGITS = 31
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rdsc_pkg::RADIX_W-1:0]    cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [VALUE_BITS-1:0]           s_value,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [rdsc_pkg::CHAR_W-1:0]          m_char,
    output logic                                 m_last,
    input  wire logic [rdsc_pkg::RADIX_W-1:0]    top_digit,
    input  wire logic                            top_carry,
    output logic                                 feed_bit,
    output logic                                 feed_en,
    output rdsc_pkg::cell_ctl_t                  ctl,
    output logic [rdsc_pkg::RADIX_W-1:0]         radix_eff
);

    localparam int CNT_W = $clog2(VALUE_BITS + MAX_DIGITS);
    localparam int E_W   = $clog2(MAX_DIGITS);
    localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(VALUE_BITS + MAX_DIGITS - 2);
    localparam logic [CNT_W-1:0] FEED_END  = CNT_W'(VALUE_BITS);
    localparam logic [E_W-1:0]   E_LAST    = E_W'(MAX_DIGITS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                      state_reg;
    logic [1:0]                      state_next;
    logic [rdsc_pkg::RADIX_W-1:0]    radix_reg;
    logic [rdsc_pkg::RADIX_W-1:0]    radix_next;
    logic [VALUE_BITS-1:0]           sr_reg;
    logic [VALUE_BITS-1:0]           sr_next;
    logic [CNT_W-1:0]                cnt_reg;
    logic [CNT_W-1:0]                cnt_next;
    logic [E_W-1:0]                  ecnt_reg;
    logic [E_W-1:0]                  ecnt_next;
    logic                            started_reg;
    logic                            started_next;
    logic                            ov_reg;
    logic                            ov_next;
    logic [rdsc_pkg::CHAR_W-1:0]     char_reg;
    logic [rdsc_pkg::CHAR_W-1:0]     char_next;
    logic                            last_reg;
    logic                            last_next;
    logic                            adv;
    logic                            emit;

    always_comb
    begin
        state_next   = state_reg;
        radix_next   = radix_reg;
        sr_next      = sr_reg;
        cnt_next     = cnt_reg;
        ecnt_next    = ecnt_reg;
        started_next = started_reg;
        ov_next      = ov_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        ctl          = '0;
        adv          = 1'b0;
        emit         = 1'b0;

        if (cfg_valid)
        begin
            radix_next = cfg_data;
        end
        if (m_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    sr_next      = s_value;
                    cnt_next     = '0;
                    started_next = 1'b0;
                    ctl.clear    = 1'b1;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctl.step     = 1'b1;
                sr_next      = sr_reg << 1;
                cnt_next     = cnt_reg + CNT_W'(1);
                // keep every digit once the value overflows the top cell
                started_next = started_reg | top_carry;
                if (cnt_reg == CONV_LAST)
                begin
                    ecnt_next  = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                adv = !ov_reg || m_ready;
                if (adv)
                begin
                    ctl.shift = 1'b1;
                    emit      = (top_digit != '0) || started_reg || top_carry
                                || (ecnt_reg == E_LAST);
                    ecnt_next = ecnt_reg + E_W'(1);
                    if (emit)
                    begin
                        ov_next      = 1'b1;
                        char_next    = rdsc_pkg::digit_to_ascii(top_digit);
                        last_next    = (ecnt_reg == E_LAST);
                        started_next = 1'b1;
                    end
                    if (ecnt_reg == E_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            radix_reg   <= rdsc_pkg::RADIX_RESET;
            cnt_reg     <= '0;
            ecnt_reg    <= '0;
            started_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            radix_reg   <= radix_next;
            cnt_reg     <= cnt_next;
            ecnt_reg    <= ecnt_next;
            started_reg <= started_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg   <= sr_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = ov_reg;
    assign m_char    = char_reg;
    assign m_last    = last_reg;
    assign feed_bit  = sr_reg[VALUE_BITS-1];
    assign feed_en   = (state_reg == ST_CONV) && (cnt_reg < FEED_END);
    assign radix_eff = rdsc_pkg::eff_radix(radix_reg);

`ifndef SYNTHESIS
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid |-> (m_char >= rdsc_pkg::ASCII_ZERO) && (m_char <= rdsc_pkg::ASCII_Z))
        else $error("character out of range");

    a_radix_range: assert property (@(posedge clk) disable iff (!rst_n)
        (radix_eff >= rdsc_pkg::RADIX_MIN) && (radix_eff <= rdsc_pkg::RADIX_MAX))
        else $error("effective radix out of range");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid && s_ready |=> (state_reg == ST_CONV) && (cnt_reg == '0))
        else $error("conversion did not start after transfer");

    a_final_char: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && adv && (ecnt_reg == E_LAST)
        |=> (state_reg == ST_IDLE) && m_valid && m_last)
        else $error("final character missing or not flagged");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/radix_digit_string_converter_core.sv =====
// ----------------------------------------------------------------------------
// radix_digit_string_converter_core
// Converts a non-negative integer into its ASCII digit string in radix 2..36,
// most significant character first, tlast on the final character.
//
// Channels: cfg_* writes the radix (always ready, write only while idle).
// s_* takes one value per transfer; m_* returns one character per transfer.
// Operation: the value bits shift MSB first through a skewed chain of
// MAX_DIGITS digit cells after the transfer. Readout then walks all
// MAX_DIGITS cell positions, one per cycle unless m_tready is low with a
// character pending, dropping leading zeros. s_tready is high only while
// idle; the next value is taken while the final character still waits in
// the output register. A low m_tready holds the readout in place.
// Reset: radix returns to 16, the channels go idle, no character is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_digit_string_converter_core #(
    parameter int VALUE_BITS = 31,
    parameter int MAX_DIGITS = 31
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [rdsc_pkg::RADIX_W-1:0]          cfg_data,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0]       s_tdata,   // value
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [7:0]                                 m_tdata,   // digit_char
    output logic                                       m_tlast
);

    rdsc_pkg::cell_ctl_t            ctl;
    logic [rdsc_pkg::RADIX_W-1:0]   radix_eff;
    logic                           feed_bit;
    logic                           feed_en;
    logic [rdsc_pkg::CHAR_W-1:0]    m_char;
    logic [rdsc_pkg::RADIX_W-1:0]   digit_w [MAX_DIGITS];
    logic                           carry_w [MAX_DIGITS];
    logic                           en_w    [MAX_DIGITS];

    rdsc_ctrl #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_value   (s_tdata[VALUE_BITS-1:0]),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_char    (m_char),
        .m_last    (m_tlast),
        .top_digit (digit_w[MAX_DIGITS-1]),
        .top_carry (carry_w[MAX_DIGITS-1]),
        .feed_bit  (feed_bit),
        .feed_en   (feed_en),
        .ctl       (ctl),
        .radix_eff (radix_eff)
    );

    for (genvar i = 0; i < MAX_DIGITS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            rdsc_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .radix     (radix_eff),
                .carry_in  (feed_bit),
                .en_in     (feed_en),
                .digit_in  ('0),
                .digit     (digit_w[i]),
                .carry_out (carry_w[i]),
                .en_out    (en_w[i])
            );
        end
        else
        begin : g_rest
            rdsc_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .radix     (radix_eff),
                .carry_in  (carry_w[i-1]),
                .en_in     (en_w[i-1]),
                .digit_in  (digit_w[i-1]),
                .digit     (digit_w[i]),
                .carry_out (carry_w[i]),
                .en_out    (en_w[i])
            );
        end
    end

    assign m_tdata = {1'b0, m_char};

endmodule

`default_nettype wire
